/* rtl/core/ces_pkg.sv */
// Package for the coalescing event scheduler.
// Holds queue sizing, operation and action codes, and queue control/status types.
// No dependencies.
package ces_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] FUNC_PUSH_TOUCH   = 3'd0;
    localparam logic [2:0] FUNC_PUSH_CONTROL = 3'd1;
    localparam logic [2:0] FUNC_KEYFRAME     = 3'd2;
    localparam logic [2:0] FUNC_TAKE         = 3'd3;
    localparam logic [2:0] FUNC_CLEAR        = 3'd4;

    localparam logic [2:0] ACT_IDLE       = 3'd0;
    localparam logic [2:0] ACT_KEYFRAME   = 3'd1;
    localparam logic [2:0] ACT_CONTROL    = 3'd2;
    localparam logic [2:0] ACT_WAIT_TOUCH = 3'd3;
    localparam logic [2:0] ACT_SEND_TOUCH = 3'd4;

    typedef struct packed {
        logic push;
        logic merge;
        logic pop;
        logic clear;
    } t_q_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             tail_coal;
        logic [31:0]      head_data;
    } t_tq_stat;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      head_code;
    } t_cq_stat;

endpackage

/* rtl/core/coalescing_event_scheduler.sv */
// Coalescing event scheduler top level: input register, decision logic, result register.
// Depends on ces_pkg, ces_touch_q and ces_ctrl_q.
//
// Usage:
//   Input channel i_valid/o_stall carries one operation per transfer (push touch,
//   push control, request keyframe, take, clear). Output channel o_valid/i_stall
//   returns exactly one result per operation, in order.
//   Configuration channel i_cfg_valid/o_cfg_ready writes min_touch_interval, always
//   ready; the user must write it only while the block is idle; no check enforces it.
//   An operation transferred into the input register executes once the result register
//   is free or being taken; its result is registered and offered from then on.
//   Throughput: one operation per cycle while i_stall is low, set by the single pass
//   from the input register through the queue update to the result register.
//   Receiver stall: the result register holds; the input register holds the next
//   operation, and o_stall rises while both are occupied and i_stall is high.
//   Reset: both queues empty, keyframe request dropped, gate disarmed, drop count
//   zero, interval zero; no clearing pass is needed.
module coalescing_event_scheduler
    import ces_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_touch_data,
    input  logic        i_touch_coalescable,
    input  logic [15:0] i_control_code,
    input  logic [31:0] i_now_ticks,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [2:0]  o_action,
    output logic [15:0] o_out_control,
    output logic [31:0] o_out_touch,
    output logic [31:0] o_wait_ticks,
    output logic [31:0] o_drop_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        r_in_v;
    logic [2:0]  r_func;
    logic [31:0] r_touch_data;
    logic        r_coal;
    logic [15:0] r_code;
    logic [31:0] r_now;

    logic        r_out_v;
    logic        r_accepted;
    logic [2:0]  r_action;
    logic [15:0] r_out_control;
    logic [31:0] r_out_touch;
    logic [31:0] r_wait;

    logic [31:0] r_min_interval;
    logic        r_keyframe;
    logic        r_armed;
    logic [31:0] r_last_send;
    logic [31:0] r_dropped;

    logic        w_exec;
    logic        w_in_take;
    t_q_cmd      w_tcmd;
    t_q_cmd      w_ccmd;
    t_tq_stat    w_tstat;
    t_cq_stat    w_cstat;
    logic [31:0] w_elapsed;

    logic        n_accepted;
    logic [2:0]  n_action;
    logic [15:0] n_out_control;
    logic [31:0] n_out_touch;
    logic [31:0] n_wait;
    logic        n_keyframe;
    logic        n_armed;
    logic [31:0] n_last_send;
    logic        n_drop;
    logic [31:0] n_dropped;

    assign w_exec    = r_in_v && (!r_out_v || !i_stall);
    assign w_in_take = !r_in_v || w_exec;
    assign o_stall   = !w_in_take;
    assign o_cfg_ready = 1'b1;
    assign w_elapsed = r_now - r_last_send;

    always_comb begin
        w_tcmd        = '0;
        w_ccmd        = '0;
        n_accepted    = 1'b0;
        n_action      = ACT_IDLE;
        n_out_control = '0;
        n_out_touch   = '0;
        n_wait        = '0;
        n_keyframe    = r_keyframe;
        n_armed       = r_armed;
        n_last_send   = r_last_send;
        n_drop        = 1'b0;
        unique case (r_func)
            FUNC_PUSH_TOUCH: begin
                if (r_coal && (w_tstat.count != '0) && w_tstat.tail_coal) begin
                    w_tcmd.merge = 1'b1;
                    n_accepted   = 1'b1;
                end else if (w_tstat.count == CNT_FULL) begin
                    n_drop = 1'b1;
                end else begin
                    w_tcmd.push = 1'b1;
                    n_accepted  = 1'b1;
                end
            end
            FUNC_PUSH_CONTROL: begin
                if (w_cstat.count == CNT_FULL) begin
                    n_drop = 1'b1;
                end else begin
                    w_ccmd.push = 1'b1;
                    n_accepted  = 1'b1;
                end
            end
            FUNC_KEYFRAME: begin
                n_keyframe = 1'b1;
            end
            FUNC_TAKE: begin
                priority if (r_keyframe) begin
                    n_keyframe = 1'b0;
                    n_action   = ACT_KEYFRAME;
                end else if (w_cstat.count != '0) begin
                    w_ccmd.pop    = 1'b1;
                    n_action      = ACT_CONTROL;
                    n_out_control = w_cstat.head_code;
                end else if (w_tstat.count == '0) begin
                    n_action = ACT_IDLE;
                end else if (r_armed && (w_elapsed < r_min_interval)) begin
                    n_action = ACT_WAIT_TOUCH;
                    n_wait   = r_min_interval - w_elapsed;
                end else begin
                    w_tcmd.pop  = 1'b1;
                    n_action    = ACT_SEND_TOUCH;
                    n_out_touch = w_tstat.head_data;
                    n_last_send = r_now;
                    n_armed     = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                w_tcmd.clear = 1'b1;
                w_ccmd.clear = 1'b1;
                n_keyframe   = 1'b0;
                n_armed      = 1'b0;
            end
            default: begin
            end
        endcase
        n_dropped = (n_drop && (r_dropped != '1)) ? r_dropped + 32'd1 : r_dropped;
        if (!w_exec) begin
            w_tcmd = '0;
            w_ccmd = '0;
        end
    end

    ces_touch_q u_touch_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_tcmd),
        .i_data  (r_touch_data),
        .i_coal  (r_coal),
        .o_stat  (w_tstat)
    );

    ces_ctrl_q u_ctrl_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ccmd),
        .i_code  (r_code),
        .o_stat  (w_cstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_take) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_valid) begin
            r_func       <= i_func;
            r_touch_data <= i_touch_data;
            r_coal       <= i_touch_coalescable;
            r_code       <= i_control_code;
            r_now        <= i_now_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v        <= 1'b0;
            r_min_interval <= '0;
            r_keyframe     <= 1'b0;
            r_armed        <= 1'b0;
            r_last_send    <= '0;
            r_dropped      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_interval <= i_cfg_data;
            end
            if (w_exec) begin
                r_out_v     <= 1'b1;
                r_keyframe  <= n_keyframe;
                r_armed     <= n_armed;
                r_last_send <= n_last_send;
                r_dropped   <= n_dropped;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_accepted    <= n_accepted;
            r_action      <= n_action;
            r_out_control <= n_out_control;
            r_out_touch   <= n_out_touch;
            r_wait        <= n_wait;
        end
    end

    assign o_valid       = r_out_v;
    assign o_accepted    = r_accepted;
    assign o_action      = r_action;
    assign o_out_control = r_out_control;
    assign o_out_touch   = r_out_touch;
    assign o_wait_ticks  = r_wait;
    assign o_drop_count  = r_dropped;

endmodule

/* rtl/core/ces_touch_q.sv */
// Touch report queue: register FIFO with tail overwrite for coalescing.
// Depends on ces_pkg.
module ces_touch_q
    import ces_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_cmd      i_cmd,
    input  logic [31:0] i_data,
    input  logic        i_coal,
    output t_tq_stat    o_stat
);

    logic [31:0]      r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_tail_coal;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] w_last;

    always_comb begin
        n_rd   = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        n_wr   = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        w_last = (r_wr == '0) ? PTR_LAST : r_wr - PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_tail_coal <= 1'b0;
        end else if (i_cmd.clear) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_wr        <= n_wr;
            r_cnt       <= r_cnt + CNT_W'(1);
            r_tail_coal <= i_coal;
        end else if (i_cmd.merge) begin
            r_tail_coal <= i_coal;
        end else if (i_cmd.pop) begin
            r_rd  <= n_rd;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr] <= i_data;
        end else if (i_cmd.merge) begin
            r_mem[w_last] <= i_data;
        end
    end

    assign o_stat.count     = r_cnt;
    assign o_stat.tail_coal = r_tail_coal;
    assign o_stat.head_data = r_mem[r_rd];

endmodule

/* rtl/core/ces_ctrl_q.sv */
// Control command queue: plain register FIFO.
// Depends on ces_pkg.
module ces_ctrl_q
    import ces_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_cmd      i_cmd,
    input  logic [15:0] i_code,
    output t_cq_stat    o_stat
);

    logic [15:0]      r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W-1:0] n_wr;

    always_comb begin
        n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_wr  <= n_wr;
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_rd  <= n_rd;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr] <= i_code;
        end
    end

    assign o_stat.count     = r_cnt;
    assign o_stat.head_code = r_mem[r_rd];

endmodule
